/* src/pcw_pkg.sv */
// Package for the PNG chunk walker: payload word types, walker phases,
// event codes and the PNG signature and chunk type constants.
// No dependencies.
package pcw_pkg;

    // Input word: one byte of the file, or the end-of-stream mark
    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } in_item_t;

    // Result word
    typedef struct packed {
        logic [2:0]  event_kind;
        logic [31:0] chunk_offset;
        logic [31:0] chunk_length;
        logic [31:0] chunk_crc;
    } out_item_t;

    // Walker result towards the output register
    typedef struct packed {
        logic      valid;
        out_item_t item;
    } pcw_result_t;

    typedef enum logic [3:0] {
        PH_SIG       = 4'd0,
        PH_IHDR_LEN  = 4'd1,
        PH_IHDR_TYPE = 4'd2,
        PH_IHDR_DATA = 4'd3,
        PH_IHDR_CRC  = 4'd4,
        PH_CH_LEN    = 4'd5,
        PH_CH_TYPE   = 4'd6,
        PH_CH_DATA   = 4'd7,
        PH_CH_CRC    = 4'd8,
        PH_IDAT_DATA = 4'd9,
        PH_IDAT_CRC  = 4'd10,
        PH_IDLE      = 4'd11
    } phase_t;

    typedef enum logic [2:0] {
        EV_SIG_OK    = 3'd0,
        EV_SIG_BAD   = 3'd1,
        EV_IHDR_OK   = 3'd2,
        EV_IHDR_MISS = 3'd3,
        EV_IDAT      = 3'd4,
        EV_IEND_OK   = 3'd5,
        EV_NO_IDAT   = 3'd6,
        EV_NO_IEND   = 3'd7
    } event_t;

    localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
    localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
    localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;
    localparam logic [31:0] POS_MAX   = 32'hFFFF_FFFF;

    // Expected signature byte at each place
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h89;
            3'd1:    b = 8'h50;
            3'd2:    b = 8'h4E;
            3'd3:    b = 8'h47;
            3'd4:    b = 8'h0D;
            3'd5:    b = 8'h0A;
            3'd6:    b = 8'h1A;
            3'd7:    b = 8'h0A;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* src/pcw_in_stage.sv */
// Input register of the PNG chunk walker: holds one word until the walker
// steps on it. Depends on pcw_pkg.
module pcw_in_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  pcw_pkg::in_item_t s_data,
    input  logic             out_free,
    output logic             step,
    output pcw_pkg::in_item_t item
);
    import pcw_pkg::*;

    logic     in_valid_reg;
    logic     in_valid_next;
    in_item_t item_reg;

    // Step whenever a word is held and the output register can take a result
    assign step    = in_valid_reg && out_free;
    assign s_ready = !in_valid_reg || step;
    assign item    = item_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
    end

    // Hold the valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Capture the payload on acceptance
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
    end

endmodule

/* src/pcw_walker.sv */
// Chunk walker state machine: signature check, IHDR check and the chunk
// walk, one byte per step. Depends on pcw_pkg.
module pcw_walker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  pcw_pkg::in_item_t   item,
    output pcw_pkg::pcw_result_t result
);
    import pcw_pkg::*;

    phase_t      phase_reg,  phase_next;
    logic [2:0]  bif_reg,    bif_next;
    logic [31:0] pos_reg,    pos_next;
    logic [31:0] len_reg,    len_next;
    logic [31:0] type_reg,   type_next;
    logic [31:0] skip_reg,   skip_next;
    logic [31:0] crc_reg,    crc_next;
    logic [31:0] start_reg,  start_next;
    logic        seen_reg,   seen_next;

    logic [7:0]  b;
    logic [31:0] len_shifted;
    logic [31:0] type_shifted;
    logic [31:0] crc_shifted;
    logic        last4;

    assign b            = item.data_byte;
    assign len_shifted  = {len_reg[23:0], b};
    assign type_shifted = {type_reg[23:0], b};
    assign crc_shifted  = {crc_reg[23:0], b};
    assign last4        = (bif_reg == 3'd3);

    // Next state and result for one byte
    always_comb begin
        phase_next = phase_reg;
        bif_next   = bif_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        type_next  = type_reg;
        skip_next  = skip_reg;
        crc_next   = crc_reg;
        start_next = start_reg;
        seen_next  = seen_reg;
        result     = '0;

        if (phase_reg != PH_IDLE) begin
            if (item.stream_end) begin
                // End of file: report where it fell and stop
                phase_next   = PH_IDLE;
                result.valid = 1'b1;
                if (phase_reg == PH_SIG) begin
                    result.item.event_kind = EV_SIG_BAD;
                end else if (phase_reg == PH_IHDR_LEN || phase_reg == PH_IHDR_TYPE) begin
                    result.item.event_kind = EV_IHDR_MISS;
                end else begin
                    result.item.event_kind = seen_reg ? EV_NO_IEND : EV_NO_IDAT;
                end
            end else begin
                if (pos_reg != POS_MAX) begin
                    pos_next = pos_reg + 32'd1;
                end
                case (phase_reg)
                    PH_SIG: begin
                        if (b != sig_byte(bif_reg)) begin
                            len_next = 32'd1;
                        end
                        bif_next = bif_reg + 3'd1;
                        if (bif_reg == 3'd7) begin
                            len_next     = '0;
                            result.valid = 1'b1;
                            if (len_reg != 32'd0 || b != sig_byte(bif_reg)) begin
                                phase_next             = PH_IDLE;
                                result.item.event_kind = EV_SIG_BAD;
                            end else begin
                                phase_next             = PH_IHDR_LEN;
                                result.item.event_kind = EV_SIG_OK;
                            end
                        end
                    end
                    PH_IHDR_LEN, PH_CH_LEN: begin
                        if (bif_reg == 3'd0) begin
                            start_next = pos_reg;
                        end
                        len_next = len_shifted;
                        bif_next = bif_reg + 3'd1;
                        if (last4) begin
                            bif_next   = '0;
                            type_next  = '0;
                            phase_next = (phase_reg == PH_IHDR_LEN) ? PH_IHDR_TYPE
                                                                    : PH_CH_TYPE;
                        end
                    end
                    PH_IHDR_TYPE: begin
                        type_next = type_shifted;
                        bif_next  = bif_reg + 3'd1;
                        if (last4) begin
                            result.valid = 1'b1;
                            if (type_shifted != TYPE_IHDR) begin
                                phase_next             = PH_IDLE;
                                result.item.event_kind = EV_IHDR_MISS;
                            end else begin
                                skip_next              = len_reg;
                                bif_next               = '0;
                                phase_next             = (len_reg != 32'd0) ? PH_IHDR_DATA
                                                                            : PH_IHDR_CRC;
                                result.item.event_kind = EV_IHDR_OK;
                            end
                        end
                    end
                    PH_CH_TYPE: begin
                        type_next = type_shifted;
                        bif_next  = bif_reg + 3'd1;
                        if (last4) begin
                            skip_next = len_reg;
                            bif_next  = '0;
                            if (type_shifted == TYPE_IDAT) begin
                                crc_next   = '0;
                                phase_next = (len_reg != 32'd0) ? PH_IDAT_DATA : PH_IDAT_CRC;
                            end else if (type_shifted == TYPE_IEND) begin
                                phase_next             = PH_IDLE;
                                result.valid           = 1'b1;
                                result.item.event_kind = seen_reg ? EV_IEND_OK : EV_NO_IDAT;
                            end else begin
                                phase_next = (len_reg != 32'd0) ? PH_CH_DATA : PH_CH_CRC;
                            end
                        end
                    end
                    PH_IHDR_DATA, PH_CH_DATA, PH_IDAT_DATA: begin
                        skip_next = skip_reg - 32'd1;
                        if (skip_reg == 32'd1) begin
                            bif_next = '0;
                            case (phase_reg)
                                PH_IHDR_DATA: phase_next = PH_IHDR_CRC;
                                PH_CH_DATA:   phase_next = PH_CH_CRC;
                                default:      phase_next = PH_IDAT_CRC;
                            endcase
                        end
                    end
                    PH_IHDR_CRC, PH_CH_CRC: begin
                        bif_next = bif_reg + 3'd1;
                        if (last4) begin
                            bif_next   = '0;
                            len_next   = '0;
                            phase_next = PH_CH_LEN;
                        end
                    end
                    PH_IDAT_CRC: begin
                        crc_next = crc_shifted;
                        bif_next = bif_reg + 3'd1;
                        if (last4) begin
                            bif_next                 = '0;
                            len_next                 = '0;
                            seen_next                = 1'b1;
                            phase_next               = PH_CH_LEN;
                            result.valid             = 1'b1;
                            result.item.event_kind   = EV_IDAT;
                            result.item.chunk_offset = start_reg;
                            result.item.chunk_length = len_reg;
                            result.item.chunk_crc    = crc_shifted;
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Advance the walker state on each step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SIG;
            bif_reg   <= '0;
            pos_reg   <= '0;
            len_reg   <= '0;
            type_reg  <= '0;
            skip_reg  <= '0;
            crc_reg   <= '0;
            start_reg <= '0;
            seen_reg  <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            bif_reg   <= bif_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            type_reg  <= type_next;
            skip_reg  <= skip_next;
            crc_reg   <= crc_next;
            start_reg <= start_next;
            seen_reg  <= seen_next;
        end
    end

endmodule

/* src/pcw_out_stage.sv */
// Output register of the PNG chunk walker: holds one result word until
// the consumer takes it. Depends on pcw_pkg.
module pcw_out_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  pcw_pkg::pcw_result_t result,
    output logic                 out_free,
    output logic                 m_valid,
    input  logic                 m_ready,
    output pcw_pkg::out_item_t   m_data
);
    import pcw_pkg::*;

    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_item_reg;

    assign out_free = !out_valid_reg || m_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_item_reg;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (step) begin
            out_valid_next = result.valid;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Hold the valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Load a new result word
    always_ff @(posedge aclk) begin
        if (step && result.valid) begin
            out_item_reg <= result.item;
        end
    end

endmodule

/* src/png_chunk_walker.sv */
// PNG chunk walker, top level. Takes one file byte per cycle, unless the
// output register is stalled, and reports signature, IHDR, IDAT and end-of-walk events.
// Result path: the result word is loaded into the output register when the walker
// steps on its byte in the input register, which waits while a result is not taken.
// Throughput: one byte per cycle while the output register is free to take a result.
// Reset: synchronous, active-low aresetn; back to the signature phase.
module png_chunk_walker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pcw_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output pcw_pkg::out_item_t m_data
);
    import pcw_pkg::*;

    logic        step;
    logic        out_free;
    in_item_t    item;
    pcw_result_t result;

    pcw_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .out_free (out_free),
        .step     (step),
        .item     (item)
    );

    pcw_walker u_walker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (item),
        .result  (result)
    );

    pcw_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .result   (result),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

/* src/pcw_checker.sv */
// Port checker for the PNG chunk walker and its bind to the top level.
// Depends on pcw_pkg and png_chunk_walker.
module pcw_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input pcw_pkg::out_item_t m_data
);
    import pcw_pkg::*;

    logic terminal;

    assign terminal = (m_data.event_kind == EV_SIG_BAD)   ||
                      (m_data.event_kind == EV_IHDR_MISS) ||
                      (m_data.event_kind == EV_IEND_OK)   ||
                      (m_data.event_kind == EV_NO_IDAT)   ||
                      (m_data.event_kind == EV_NO_IEND);

    // Reset empties the output register
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // Only IDAT words carry offset, length and CRC
    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.event_kind != EV_IDAT |->
        m_data.chunk_offset == 32'd0 && m_data.chunk_length == 32'd0 &&
        m_data.chunk_crc == 32'd0)
        else $error("non-IDAT event with nonzero fields");

    // A final event is followed by silence
    a_final_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && terminal |=> !m_valid)
        else $error("result after final event");

    // A signature verdict follows a byte taken through the input register, or is a stalled word
    a_sig_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.event_kind == EV_SIG_OK |-> $past(s_valid && s_ready, 2) ||
        $past(m_valid && !m_ready))
        else $error("signature verdict without a byte behind it");

endmodule

bind png_chunk_walker pcw_checker u_pcw_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
